// ----- design/affine_block_transposer_defines.svh -----
// Assertion macros for the affine block transposer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef AFFINE_BLOCK_TRANSPOSER_DEFINES_SVH
`define AFFINE_BLOCK_TRANSPOSER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define ABT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define ABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/abt_pkg.sv -----
// Package of the affine block transposer: widths, constants, command and
// write-port types and the emitter state type. No dependencies.
`timescale 1ns / 1ps

package abt_pkg;

  // Upper bound of the block depth parameter; the shared widths follow it.
  localparam int MaxBlockHi  = 64;
  localparam int MaxBlockDef = 16;
  localparam int CntW        = $clog2(MaxBlockHi + 1);
  localparam int IdxW        = $clog2(MaxBlockHi);

  localparam int ByteW       = 8;
  localparam int BsW         = 5;
  localparam int CfgIdxW     = 2;
  localparam int StepW       = $clog2(ByteW);

  localparam logic [ByteW-1:0] PadByte = 8'd96;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgBlockSize = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMult      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOffset    = 2'd2;

  localparam logic [BsW-1:0]   BlockSizeRst = 5'd4;
  localparam logic [ByteW-1:0] MultRst      = 8'd1;
  localparam logic [ByteW-1:0] OffsetRst    = 8'd0;

  // One closed block waiting to be emitted.
  typedef struct packed {
    logic            bank;
    logic [CntW-1:0] size;
    logic [CntW-1:0] count;
    logic            eom;
  } cmd_t;

  // Write into the block buffer.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IdxW-1:0]  idx;
    logic [ByteW-1:0] data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_EMIT
  } bk_state_e;

endpackage

// ----- design/abt_front.sv -----
// Front end: takes message words, places them in the current buffer bank
// and closes a block into a command. Uses abt_pkg.
`timescale 1ns / 1ps

module abt_front #(
  parameter int MAX_BLOCK = abt_pkg::MaxBlockDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [abt_pkg::BsW-1:0]  block_size_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [abt_pkg::ByteW-1:0] in_data_i,
  input  logic                     in_eom_i,
  output abt_pkg::mem_wr_t         mem_wr_o,
  output logic                     cmd_push_o,
  output abt_pkg::cmd_t            cmd_o,
  input  logic                     cmd_full_i
);
  import abt_pkg::*;

  logic [CntW-1:0] fill_q, fill_d;
  logic            bank_q, bank_d;
  logic [CntW-1:0] eff_size;
  logic [CntW-1:0] pos;
  logic [CntW-1:0] count;
  logic            accept;
  logic            flush;

  // Size 0 acts as 1, anything above the buffer depth as the depth.
  always_comb begin
    if (block_size_i == '0) begin
      eff_size = CntW'(1);
    end else if (int'(block_size_i) > MAX_BLOCK) begin
      eff_size = CntW'(MAX_BLOCK);
    end else begin
      eff_size = CntW'(block_size_i);
    end
  end

  assign in_ready_o = !cmd_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pos        = (fill_q < eff_size) ? fill_q : (eff_size - CntW'(1));
  assign count      = pos + CntW'(1);
  assign flush      = (count >= eff_size) || in_eom_i;

  always_comb begin
    mem_wr_o.en   = accept;
    mem_wr_o.bank = bank_q;
    mem_wr_o.idx  = IdxW'(pos);
    mem_wr_o.data = in_data_i;
    cmd_push_o    = accept && flush;
    cmd_o.bank    = bank_q;
    cmd_o.size    = eff_size;
    cmd_o.count   = count;
    cmd_o.eom     = in_eom_i;
  end

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    if (accept) begin
      if (flush) begin
        fill_d = '0;
        bank_d = !bank_q;
      end else begin
        fill_d = count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
    end
  end

endmodule

// ----- design/abt_cmd_fifo.sv -----
// Two-entry queue of closed-block commands between front and back end.
// One entry per buffer bank. Uses abt_pkg.
`timescale 1ns / 1ps

module abt_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  abt_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output abt_pkg::cmd_t head_o
);
  import abt_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- design/abt_back.sv -----
// Back end: block buffer memory, residue unit and permuted emitter with
// its output register. Uses abt_pkg and the assertion macro header.
`timescale 1ns / 1ps

module abt_back #(
  parameter int MAX_BLOCK = abt_pkg::MaxBlockDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [abt_pkg::ByteW-1:0] mult_i,
  input  logic [abt_pkg::ByteW-1:0] offset_i,
  input  abt_pkg::mem_wr_t          mem_wr_i,
  input  logic                      cmd_valid_i,
  input  abt_pkg::cmd_t             cmd_i,
  output logic                      cmd_pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [abt_pkg::ByteW-1:0] out_data_o,
  output logic                      out_block_end_o,
  output logic                      out_msg_end_o
);
  import abt_pkg::*;
`include "affine_block_transposer_defines.svh"

  localparam int Depth = 2 * MAX_BLOCK;
  localparam int AddrW = $clog2(Depth);

  logic [ByteW-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;

  bk_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [CntW-1:0] rm_q, rm_d;
  logic [CntW-1:0] ro_q, ro_d;
  logic [CntW-1:0] src_q, src_d;
  logic [CntW-1:0] i_q, i_d;

  logic [CntW:0]   rm_sh, ro_sh, src_sum;
  logic [CntW-1:0] rm_nx, ro_nx, src_nx;
  logic            prep_done;
  logic            load;
  logic            last;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] rd_q;
  logic             pad_q;
  logic             blk_end_q;
  logic             msg_end_q;

  assign wr_addr = AddrW'(int'(mem_wr_i.bank) * MAX_BLOCK + int'(mem_wr_i.idx));
  assign rd_addr = AddrW'(int'(cmd_i.bank) * MAX_BLOCK + int'(src_q));

  // One restoring step per cycle for mult and offset modulo the block size.
  always_comb begin
    rm_sh = {rm_q, mult_i[StepW'(ByteW - 1) - step_q]};
    ro_sh = {ro_q, offset_i[StepW'(ByteW - 1) - step_q]};
    rm_nx = (rm_sh >= {1'b0, cmd_i.size}) ? CntW'(rm_sh - {1'b0, cmd_i.size}) : CntW'(rm_sh);
    ro_nx = (ro_sh >= {1'b0, cmd_i.size}) ? CntW'(ro_sh - {1'b0, cmd_i.size}) : CntW'(ro_sh);
    src_sum = {1'b0, src_q} + {1'b0, rm_q};
    src_nx  = (src_sum >= {1'b0, cmd_i.size}) ? CntW'(src_sum - {1'b0, cmd_i.size})
                                              : CntW'(src_sum);
  end

  assign prep_done = (step_q == StepW'(ByteW - 1));
  assign last      = (i_q == cmd_i.size - CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          state_d = BK_PREP;
        end
      end
      BK_PREP: begin
        if (prep_done) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (load && last) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    load        = 1'b0;
    cmd_pop_o   = 1'b0;
    step_d      = step_q;
    rm_d        = rm_q;
    ro_d        = ro_q;
    src_d       = src_q;
    i_d         = i_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      BK_IDLE: begin
        step_d = '0;
        rm_d   = '0;
        ro_d   = '0;
      end
      BK_PREP: begin
        step_d = step_q + StepW'(1);
        rm_d   = rm_nx;
        ro_d   = ro_nx;
        if (prep_done) begin
          src_d = ro_nx;
          i_d   = '0;
        end
      end
      BK_EMIT: begin
        load = !out_valid_q || out_ready_i;
        if (load) begin
          out_valid_d = 1'b1;
          src_d       = src_nx;
          i_d         = i_q + CntW'(1);
          cmd_pop_o   = last;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      i_q         <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rm_q  <= rm_d;
    ro_q  <= ro_d;
    src_q <= src_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_wr_i.en) begin
      mem_q[wr_addr] <= mem_wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rd_q      <= mem_q[rd_addr];
      pad_q     <= (src_q >= cmd_i.count);
      blk_end_q <= last;
      msg_end_q <= last && cmd_i.eom;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = pad_q ? PadByte : rd_q;
  assign out_block_end_o = blk_end_q;
  assign out_msg_end_o   = msg_end_q;

  `ABT_ASSERT(a_src_in_block, clk_i, rst_ni, (state_q != BK_EMIT) || (src_q < cmd_i.size), "source index outside block")
  `ABT_ASSERT(a_step_in_block, clk_i, rst_ni, (state_q != BK_EMIT) || (i_q < cmd_i.size), "output position outside block")
  `ABT_ASSERT(a_stride_reduced, clk_i, rst_ni, (state_q != BK_EMIT) || (rm_q < cmd_i.size), "stride residue not reduced")
  `ABT_ASSERT(a_pop_has_cmd, clk_i, rst_ni, !cmd_pop_o || cmd_valid_i, "pop of an empty command queue")
  `ABT_ASSERT_NEXT(a_prep_to_emit, clk_i, rst_ni, (state_q == BK_PREP) && prep_done, state_q == BK_EMIT, "residue pass did not end in emission")

endmodule

// ----- design/affine_block_transposer.sv -----
// Affine block transposer: message words are gathered into blocks and sent
// out in the order (mult*i + offset) mod size. Top level; configuration
// registers. Uses abt_pkg, abt_front, abt_cmd_fifo and abt_back.
//
// Usage. Message words arrive on the s_axis channel, one byte in tdata; tlast
// marks the last word of a message. A block closes when it holds the
// effective block size of words (size 0 counts as 1, sizes above MAX_BLOCK
// as MAX_BLOCK), or at once on a tlast word, the missing positions then
// reading as the pad byte 96. Each closed block leaves on m_axis as exactly
// size words; tuser flags the last word of every block and tlast the last
// word of a message. Registers are written through the cfg channel, which
// is always ready, and must only be changed while the block is idle.
// Throughput: the front end takes one word per cycle into one of two buffer
// banks while the command queue is not full; the back end picks up a block
// from its idle state, runs a bit-serial residue pass over the bits of mult
// and offset, then emits one word per cycle while m_axis is not stalled.
// Reset clears the fill count, the bank pointers, the command queue and the
// output valid flag and loads the register defaults (size 4, mult 1,
// offset 0); buffer contents need no reset as they are written before use.
// A stall on m_axis holds the output word; the front end keeps filling the
// free bank and stops taking words only when both banks hold closed blocks.
`timescale 1ns / 1ps

module affine_block_transposer #(
  parameter int MAX_BLOCK = abt_pkg::MaxBlockDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Message words in.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [abt_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] data_in
  input  logic                        s_axis_tlast,   // end_of_message
  // Permuted words out.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [abt_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] data_out
  output logic                        m_axis_tuser,   // [0] block_end
  output logic                        m_axis_tlast,   // message_end
  // Configuration writes.
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [abt_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [abt_pkg::ByteW-1:0]   cfg_data_i
);
  import abt_pkg::*;

  logic [BsW-1:0]   block_size_q, block_size_d;
  logic [ByteW-1:0] mult_q, mult_d;
  logic [ByteW-1:0] offset_q, offset_d;

  mem_wr_t mem_wr;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  logic    cmd_push;
  logic    cmd_full;
  logic    cmd_pop;
  logic    cmd_valid;

  // Register writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    block_size_d = block_size_q;
    mult_d       = mult_q;
    offset_d     = offset_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBlockSize: block_size_d = cfg_data_i[BsW-1:0];
        CfgMult:      mult_d       = cfg_data_i;
        CfgOffset:    offset_d     = cfg_data_i;
        default:      block_size_d = block_size_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BlockSizeRst;
      mult_q       <= MultRst;
      offset_q     <= OffsetRst;
    end else begin
      block_size_q <= block_size_d;
      mult_q       <= mult_d;
      offset_q     <= offset_d;
    end
  end

  abt_front #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .block_size_i (block_size_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_eom_i     (s_axis_tlast),
    .mem_wr_o     (mem_wr),
    .cmd_push_o   (cmd_push),
    .cmd_o        (push_cmd),
    .cmd_full_i   (cmd_full)
  );

  abt_cmd_fifo u_cmd_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (cmd_push),
    .push_cmd_i (push_cmd),
    .full_o     (cmd_full),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (head_cmd)
  );

  abt_back #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .mult_i          (mult_q),
    .offset_i        (offset_q),
    .mem_wr_i        (mem_wr),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (head_cmd),
    .cmd_pop_o       (cmd_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_data_o      (m_axis_tdata),
    .out_block_end_o (m_axis_tuser),
    .out_msg_end_o   (m_axis_tlast)
  );

endmodule

// ----- test/tb_affine_block_transposer.sv -----
// Self-checking testbench of affine_block_transposer: a directed table, then
// random messages under random source gaps and sink stalls. Depends on abt_pkg.
`timescale 1ns / 1ps

module tb_affine_block_transposer;
  import abt_pkg::*;

  localparam int MaxBlk = MaxBlockDef;
  localparam int SettleCycles = 40;
  localparam int CycleLimit = 300000;
  localparam int PrintCap = 40;
  // Index 3 names no register; a write to it must change nothing.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  // One permuted word as seen on the master side.
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             blk_end;
    logic             msg_end;
  } out_word_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_CFG
  } row_kind_e;

  // A row of the directed table: either a message word or a register write.
  // Where typed is set, want is the single word that the row must produce.
  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [ByteW-1:0]   data;
    logic               eom;
    logic               typed;
    out_word_t          want;
  } stim_row_t;

  localparam out_word_t NoWant = '0;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [ByteW-1:0]   s_axis_tdata;
  logic               s_axis_tlast;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [ByteW-1:0]   m_axis_tdata;
  logic               m_axis_tuser;
  logic               m_axis_tlast;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [ByteW-1:0]   cfg_data_i;

  // Shadow of the block: register copies, fill count and block buffer.
  logic [BsW-1:0]   reg_size = BlockSizeRst;
  logic [ByteW-1:0] reg_mult = MultRst;
  logic [ByteW-1:0] reg_offset = OffsetRst;
  int               fill_cnt = 0;
  logic [ByteW-1:0] blk_buf [MaxBlk];

  out_word_t staged [$];       // words caused by the latest accepted word
  out_word_t pending_out [$];  // words still owed by the block, oldest first
  out_word_t head_word;

  int fail_count = 0;
  int cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b1;

  stim_row_t plan [$];

  affine_block_transposer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Every mismatch passes through here; printing stops after a while so that a
  // badly broken block cannot flood the log, but the count goes on.
  task automatic flag_mismatch(input string what);
    fail_count++;
    if (fail_count <= PrintCap) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
  endtask

  // Block size as the hardware uses it: 0 counts as 1, anything above the
  // buffer depth as the full depth.
  function automatic int eff_blk();
    if (reg_size == 0) begin
      return 1;
    end
    return (int'(reg_size) > MaxBlk) ? MaxBlk : int'(reg_size);
  endfunction

  // Takes one accepted message word into the shadow buffer and, when the
  // block closes, leaves its permuted words in staged.
  function automatic void transpose_word(input logic [ByteW-1:0] msg_byte,
                                         input logic eom);
    int n;
    int pos;
    int cnt;
    out_word_t w;
    n = eff_blk();
    staged.delete();
    // A block size lowered under a partly filled block makes the new word
    // land on the last position, which then closes the block at once.
    pos = (fill_cnt < n) ? fill_cnt : n - 1;
    blk_buf[pos] = msg_byte;
    cnt = pos + 1;
    if (cnt < n && !eom) begin
      fill_cnt = cnt;
      return;
    end
    for (int i = cnt; i < n; i++) begin
      blk_buf[i] = PadByte;
    end
    for (int i = 0; i < n; i++) begin
      w.data    = blk_buf[(int'(reg_mult) * i + int'(reg_offset)) % n];
      w.blk_end = (i == n - 1);
      w.msg_end = (i == n - 1) && eom;
      staged.push_back(w);
    end
    fill_cnt = 0;
  endfunction

  // Offers one message word, with an occasional gap in front of it, and books
  // what it causes once the block has taken it.
  task automatic send_word(input logic [ByteW-1:0] d, input logic eom,
                           input logic typed, input out_word_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= eom;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    transpose_word(d, eom);
    if (typed) begin
      pending_out.push_back(want);
    end else begin
      foreach (staged[k]) pending_out.push_back(staged[k]);
    end
  endtask

  // One register write. The channel is dropped for a cycle afterwards, so
  // back-to-back writes never lower and raise valid in the same step.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CfgBlockSize: reg_size = val[BsW-1:0];
      CfgMult:      reg_mult = val;
      CfgOffset:    reg_offset = val;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Brings the block to rest before the registers change: all owed words out,
  // then enough cycles for a block that is still being emitted or picked up.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Sink: checks each accepted word against the oldest expectation and stalls
  // in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_out.size() == 0) begin
          flag_mismatch($sformatf("word %02h arrived with nothing expected", m_axis_tdata));
        end else begin
          head_word = pending_out.pop_front();
          if (m_axis_tdata !== head_word.data) begin
            flag_mismatch($sformatf("data %02h, expected %02h", m_axis_tdata, head_word.data));
          end
          if (m_axis_tuser !== head_word.blk_end) begin
            flag_mismatch($sformatf("block end %b, expected %b", m_axis_tuser,
                                    head_word.blk_end));
          end
          if (m_axis_tlast !== head_word.msg_end) begin
            flag_mismatch($sformatf("message end %b, expected %b", m_axis_tlast,
                                    head_word.msg_end));
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) begin
          m_axis_tready <= 1'b1;
        end
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: a run that never drains ends here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("affine_block_transposer verification failed");
      $finish;
    end
  end

  initial begin
    int sent;
    int len;
    int pick;
    logic [ByteW-1:0] v;

    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CfgBlockSize;
    cfg_data_i    <= '0;

    plan = '{
      // Reset defaults: blocks of four in arrival order.
      '{ROW_WORD, CfgBlockSize, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'hFF, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h5A, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'hA5, 1'b0, 1'b0, NoWant},
      // End of message on a lone word: three pad bytes follow it.
      '{ROW_WORD, CfgBlockSize, 8'h3C, 1'b1, 1'b0, NoWant},
      // Size 0 acts as 1, so each word comes straight back as its own block.
      '{ROW_CFG,  CfgBlockSize, 8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{ROW_WORD, CfgBlockSize, 8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      // Size field 31 clamps to the full depth; high data bits are dropped.
      '{ROW_CFG,  CfgBlockSize, 8'hFF, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgMult,      8'h03, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgOffset,    8'hFF, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h81, 1'b1, 1'b0, NoWant},
      // A full block that also ends the message; mult 0 repeats one byte.
      '{ROW_CFG,  CfgBlockSize, 8'h02, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgMult,      8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgOffset,    8'h01, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h11, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h22, 1'b1, 1'b0, NoWant},
      // Size lowered under three held words: the next word closes the block.
      '{ROW_CFG,  CfgBlockSize, 8'h04, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgMult,      8'hFF, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgOffset,    8'h00, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h01, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h02, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h03, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgBlockSize, 8'h02, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h04, 1'b0, 1'b0, NoWant},
      // A write to the unused index leaves every register alone.
      '{ROW_CFG,  CfgUnused,    8'hAA, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgBlockSize, 8'h10, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgMult,      8'h05, 1'b0, 1'b0, NoWant},
      '{ROW_CFG,  CfgOffset,    8'h80, 1'b0, 1'b0, NoWant},
      '{ROW_WORD, CfgBlockSize, 8'h7E, 1'b1, 1'b0, NoWant}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. A run of register writes is preceded by one settle.
    foreach (plan[r]) begin
      if (plan[r].kind == ROW_CFG) begin
        if (r == 0 || plan[r-1].kind == ROW_WORD) begin
          quiesce();
        end
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_word(plan[r].data, plan[r].eom, plan[r].typed, plan[r].want);
      end
    end

    // Random phases, each under a fresh setting. Mostly whole messages that
    // end on a word with tlast; the rest are stray words with random tlast,
    // which also leave blocks half filled across a setting change. The final
    // phase runs without any idling on either side.
    for (int p = 0; p < 6; p++) begin
      quiesce();
      idle_on = (p < 5);
      pick = $urandom_range(0, 7);
      v = (pick == 0) ? 8'($urandom_range(0, 255)) :
          (pick == 1) ? 8'(MaxBlk) : 8'($urandom_range(1, 6));
      write_reg(CfgBlockSize, v);
      pick = $urandom_range(0, 5);
      v = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      write_reg(CfgMult, v);
      pick = $urandom_range(0, 5);
      v = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom_range(0, 255));
      write_reg(CfgOffset, v);
      if ($urandom_range(0, 3) == 0) begin
        write_reg(CfgUnused, 8'($urandom_range(0, 255)));
      end
      sent = 0;
      while (sent < 45) begin
        if ($urandom_range(0, 4) != 0) begin
          len = $urandom_range(1, 2 * eff_blk() + 1);
          for (int j = 0; j < len; j++) begin
            send_word(8'($urandom_range(0, 255)), j == len - 1, 1'b0, NoWant);
          end
          sent += len;
        end else begin
          send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, NoWant);
          sent++;
        end
      end
    end

    // Drain: every owed word must come out, and nothing more afterwards.
    s_axis_tvalid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("affine_block_transposer verification clean");
    end else begin
      $display("affine_block_transposer verification failed");
    end
    $finish;
  end

endmodule
